// File: sv/gpu_draw_environment_registers_assert.svh
// Assertion helpers for the draw environment register block
`ifndef GPU_DRAW_ENVIRONMENT_REGISTERS_ASSERT_SVH
`define GPU_DRAW_ENVIRONMENT_REGISTERS_ASSERT_SVH

// same-cycle implication
`define GDER_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("draw environment assertion failed");

// next-cycle implication
`define GDER_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("draw environment assertion failed");

`endif

// File: sv/gder_pkg.sv
`timescale 1ns / 1ps

package gder_pkg;

    localparam int OPCODE_W = 3;
    localparam int PARAM_W  = 24;
    localparam int OUT_W    = 48;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_TEX_WINDOW = 3'd0;
    localparam t_opcode OP_AREA_START = 3'd1;
    localparam t_opcode OP_AREA_END   = 3'd2;
    localparam t_opcode OP_DRAW_OFS   = 3'd3;
    localparam t_opcode OP_INFO       = 3'd4;

    typedef logic [3:0] t_info;

    localparam t_info INFO_TEX_WINDOW = 4'd2;
    localparam t_info INFO_AREA_START = 4'd3;
    localparam t_info INFO_AREA_END   = 4'd4;
    localparam t_info INFO_DRAW_OFS   = 4'd5;
    localparam t_info INFO_VERSION    = 4'd7;

    localparam logic [PARAM_W-1:0] VERSION_STD    = 24'd2;
    localparam logic [PARAM_W-1:0] VERSION_ARCADE = 24'd1;

    // index of lowest set bit, 5 when the field is zero
    function automatic logic [2:0] lowest_shift(input logic [4:0] field);
        logic [2:0] sh;
        sh = 3'd5;
        for (int b = 4; b >= 0; b--) begin
            if (field[b]) begin
                sh = 3'(b);
            end
        end
        return sh;
    endfunction

endpackage

// File: sv/gpu_draw_environment_registers.sv
// Drawing environment register block.
// The result item becomes valid in the cycle after its input item is accepted.
// Throughput: 1 item per cycle while downstream is ready; a registered output stage takes the next
// item in the same cycle the current result leaves (ready = !valid | downstream ready).
// Reset (i_rst_n low, synchronous): all state zero, arcade_mode 0,
// vram_rows_512 1, output empty.
`timescale 1ns / 1ps
`include "gpu_draw_environment_registers_assert.svh"

module gpu_draw_environment_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [23:0] params
    input  logic [2:0]  i_s_tuser,   // [2:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [23:0] read_data, [24] window_enabled, [35:25] offset_x (signed),
    // [46:36] offset_y (signed), [47] zero
    output logic [47:0] o_m_tdata
);

    localparam logic CFG_ARCADE   = 1'b0;
    localparam logic CFG_VRAM_512 = 1'b1;

    logic r_arcade, r_vram_512;

    logic [8:0]  r_mask_w, r_mask_h, n_mask_w, n_mask_h;
    logic [7:0]  r_win_off_x, r_win_off_y, n_win_off_x, n_win_off_y;
    logic        r_window_on, n_window_on;
    logic [9:0]  r_area_left, r_area_top, r_area_right, r_area_bottom;
    logic [9:0]  n_area_left, n_area_top, n_area_right, n_area_bottom;
    logic [10:0] r_draw_off_x, r_draw_off_y, n_draw_off_x, n_draw_off_y;
    logic [23:0] r_read_buffer, n_read_buffer;

    logic        r_out_valid;
    logic [47:0] r_out_data;

    logic        w_accept;
    logic [23:0] w_p;
    logic [2:0]  w_sh_w, w_sh_h;
    logic [4:0]  w_keep_x, w_keep_y;
    logic [9:0]  w_area_y;
    logic [10:0] w_draw_y;
    logic [23:0] w_info_tex, w_info_start, w_info_end, w_info_ofs;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_p        = i_s_tdata;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_sh_w   = gder_pkg::lowest_shift(w_p[4:0]);
    assign w_sh_h   = gder_pkg::lowest_shift(w_p[9:5]);
    assign w_keep_x = 5'h1F << w_sh_w;
    assign w_keep_y = 5'h1F << w_sh_h;

    assign w_area_y = r_vram_512 ? {1'b0, w_p[18:10]} :
                      (r_arcade ? w_p[21:12] : w_p[19:10]);
    assign w_draw_y = r_arcade ? w_p[22:12] : w_p[21:11];

    assign w_info_tex = 24'(r_mask_w) | (24'(r_mask_h) << 5) |
                        (24'(r_win_off_x) << 10) | (24'(r_win_off_y) << 15);
    assign w_info_start = 24'(r_area_left) |
                          (r_arcade ? (24'(r_area_top) << 12) : (24'(r_area_top) << 10));
    assign w_info_end = 24'(r_area_right) |
                        (r_arcade ? (24'(r_area_bottom) << 12) : (24'(r_area_bottom) << 10));
    assign w_info_ofs = 24'(r_draw_off_x) |
                        (r_arcade ? (24'(r_draw_off_y) << 12) : (24'(r_draw_off_y) << 11));

    always_comb begin
        n_mask_w      = r_mask_w;
        n_mask_h      = r_mask_h;
        n_win_off_x   = r_win_off_x;
        n_win_off_y   = r_win_off_y;
        n_window_on   = r_window_on;
        n_area_left   = r_area_left;
        n_area_top    = r_area_top;
        n_area_right  = r_area_right;
        n_area_bottom = r_area_bottom;
        n_draw_off_x  = r_draw_off_x;
        n_draw_off_y  = r_draw_off_y;
        n_read_buffer = r_read_buffer;
        if (w_accept) begin
            unique case (i_s_tuser)
                gder_pkg::OP_TEX_WINDOW: begin
                    n_mask_w    = 9'd8 << w_sh_w;
                    n_mask_h    = 9'd8 << w_sh_h;
                    n_win_off_x = {w_p[14:10] & w_keep_x, 3'b000};
                    n_win_off_y = {w_p[19:15] & w_keep_y, 3'b000};
                    n_window_on = (|w_p[9:0]) || (|(w_p[14:10] & w_keep_x)) ||
                                  (|(w_p[19:15] & w_keep_y));
                end
                gder_pkg::OP_AREA_START: begin
                    n_area_left = w_p[9:0];
                    n_area_top  = w_area_y;
                end
                gder_pkg::OP_AREA_END: begin
                    n_area_right  = w_p[9:0];
                    n_area_bottom = w_area_y;
                end
                gder_pkg::OP_DRAW_OFS: begin
                    n_draw_off_x = w_p[10:0];
                    n_draw_off_y = w_draw_y;
                end
                gder_pkg::OP_INFO: begin
                    case (w_p[3:0])
                        gder_pkg::INFO_TEX_WINDOW: n_read_buffer = w_info_tex;
                        gder_pkg::INFO_AREA_START: n_read_buffer = w_info_start;
                        gder_pkg::INFO_AREA_END:   n_read_buffer = w_info_end;
                        gder_pkg::INFO_DRAW_OFS:   n_read_buffer = w_info_ofs;
                        gder_pkg::INFO_VERSION: begin
                            n_read_buffer = r_arcade ? gder_pkg::VERSION_ARCADE :
                                                       gder_pkg::VERSION_STD;
                        end
                        default: n_read_buffer = r_read_buffer;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arcade      <= 1'b0;
            r_vram_512    <= 1'b1;
            r_mask_w      <= '0;
            r_mask_h      <= '0;
            r_win_off_x   <= '0;
            r_win_off_y   <= '0;
            r_window_on   <= 1'b0;
            r_area_left   <= '0;
            r_area_top    <= '0;
            r_area_right  <= '0;
            r_area_bottom <= '0;
            r_draw_off_x  <= '0;
            r_draw_off_y  <= '0;
            r_read_buffer <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_ARCADE) begin
                    r_arcade <= i_cfg_wdata;
                end
                if (i_cfg_addr == CFG_VRAM_512) begin
                    r_vram_512 <= i_cfg_wdata;
                end
            end
            r_mask_w      <= n_mask_w;
            r_mask_h      <= n_mask_h;
            r_win_off_x   <= n_win_off_x;
            r_win_off_y   <= n_win_off_y;
            r_window_on   <= n_window_on;
            r_area_left   <= n_area_left;
            r_area_top    <= n_area_top;
            r_area_right  <= n_area_right;
            r_area_bottom <= n_area_bottom;
            r_draw_off_x  <= n_draw_off_x;
            r_draw_off_y  <= n_draw_off_y;
            r_read_buffer <= n_read_buffer;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, n_draw_off_y, n_draw_off_x, n_window_on, n_read_buffer};
        end
    end

    `GDER_ASSERT_NEXT(a_accept_gives_item, w_accept, o_m_tvalid)
    `GDER_ASSERT_NEXT(a_mask_pow2, w_accept && i_s_tuser == gder_pkg::OP_TEX_WINDOW,
                      $onehot(r_mask_w) && $onehot(r_mask_h))
    `GDER_ASSERT_NOW(a_offset_enables, r_win_off_x != 8'd0 || r_win_off_y != 8'd0,
                     r_window_on)
    `GDER_ASSERT_NOW(a_out_tracks_state, o_m_tvalid,
                     o_m_tdata[35:25] == r_draw_off_x && o_m_tdata[46:36] == r_draw_off_y &&
                     o_m_tdata[23:0] == r_read_buffer)
    `GDER_ASSERT_NEXT(a_bad_op_holds, w_accept && i_s_tuser > gder_pkg::OP_INFO,
                      $stable(r_read_buffer) && $stable(r_draw_off_x))

endmodule

// File: sim/gpu_draw_environment_registers_test.sv
`timescale 1ns / 1ps

module gpu_draw_environment_registers_test;

    localparam gder_pkg::t_opcode OP_NOP_5 = 3'd5;
    localparam gder_pkg::t_opcode OP_NOP_6 = 3'd6;
    localparam gder_pkg::t_opcode OP_NOP_7 = 3'd7;

    localparam gder_pkg::t_info INFO_RESERVED_LOW  = 4'd0;
    localparam gder_pkg::t_info INFO_RESERVED_HIGH = 4'd15;

    localparam logic REG_ARCADE_MODE   = 1'b0;
    localparam logic REG_VRAM_ROWS_512 = 1'b1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int RANDOM_PHASES  = 8;

    typedef struct packed {
        logic [23:0]        read_data;
        logic               window_enabled;
        logic signed [10:0] offset_x;
        logic signed [10:0] offset_y;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // [23:0] params
    logic [2:0]  i_s_tuser;   // [2:0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [23:0] read_data, [24] window_enabled, [35:25] offset_x, [46:36] offset_y, [47] zero
    logic [47:0] o_m_tdata;

    // predicted register state
    logic        arcade_sel = 1'b0;
    logic        rows_512   = 1'b1;
    logic [8:0]  mask_w     = '0;
    logic [8:0]  mask_h     = '0;
    logic [7:0]  win_ofs_x  = '0;
    logic [7:0]  win_ofs_y  = '0;
    logic        win_on     = 1'b0;
    logic [9:0]  area_l     = '0;
    logic [9:0]  area_t     = '0;
    logic [9:0]  area_r     = '0;
    logic [9:0]  area_b     = '0;
    logic [10:0] ofs_x      = '0;
    logic [10:0] ofs_y      = '0;
    logic [23:0] readback   = '0;

    t_status     expected_status[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          burst_left     = 0;
    logic [9:0]  rx_cycle       = '0;

    gpu_draw_environment_registers u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern, stepped through by the top two bits of rx_cycle
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 10'd1;
        case (rx_cycle[9:8])
            2'd0: begin
                i_m_tready <= 1'b1;
            end
            2'd1: begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                i_m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_m_tready <= (rx_cycle[3:0] == 4'd0);
            end
        endcase
    end

    function automatic logic [8:0] texel_span(input logic [4:0] field);
        logic [8:0] span;
        span = 9'd256;
        for (int b = 4; b >= 0; b--) begin
            if (field[b]) begin
                span = 9'd8 << b;
            end
        end
        return span;
    endfunction

    function automatic logic [9:0] area_row(input logic [23:0] prm);
        if (rows_512) begin
            return {1'b0, prm[18:10]};
        end else if (arcade_sel) begin
            return prm[21:12];
        end
        return prm[19:10];
    endfunction

    task automatic apply_command(input gder_pkg::t_opcode op, input logic [23:0] prm);
        logic [4:0] clear_x;
        logic [4:0] clear_y;
        int         ysh;
        t_status    st;
        ysh = arcade_sel ? 12 : 10;
        case (op)
            gder_pkg::OP_TEX_WINDOW: begin
                mask_w    = texel_span(prm[4:0]);
                mask_h    = texel_span(prm[9:5]);
                clear_x   = 5'(mask_w >> 3) - 5'd1;
                clear_y   = 5'(mask_h >> 3) - 5'd1;
                win_ofs_x = {prm[14:10] & ~clear_x, 3'b000};
                win_ofs_y = {prm[19:15] & ~clear_y, 3'b000};
                win_on    = (win_ofs_x != 0) || (win_ofs_y != 0) ||
                            (mask_w < 9'd256) || (mask_h < 9'd256);
            end
            gder_pkg::OP_AREA_START: begin
                area_l = prm[9:0];
                area_t = area_row(prm);
            end
            gder_pkg::OP_AREA_END: begin
                area_r = prm[9:0];
                area_b = area_row(prm);
            end
            gder_pkg::OP_DRAW_OFS: begin
                ofs_x = prm[10:0];
                ofs_y = arcade_sel ? prm[22:12] : prm[21:11];
            end
            gder_pkg::OP_INFO: begin
                case (gder_pkg::t_info'(prm[3:0]))
                    gder_pkg::INFO_TEX_WINDOW: begin
                        readback = 24'({23'd0, mask_w} | ({23'd0, mask_h} << 5) |
                                       ({24'd0, win_ofs_x} << 10) |
                                       ({24'd0, win_ofs_y} << 15));
                    end
                    gder_pkg::INFO_AREA_START: begin
                        readback = 24'({22'd0, area_l} | ({22'd0, area_t} << ysh));
                    end
                    gder_pkg::INFO_AREA_END: begin
                        readback = 24'({22'd0, area_r} | ({22'd0, area_b} << ysh));
                    end
                    gder_pkg::INFO_DRAW_OFS: begin
                        readback = 24'({21'd0, ofs_x} |
                                       ({21'd0, ofs_y} << (arcade_sel ? 12 : 11)));
                    end
                    gder_pkg::INFO_VERSION: begin
                        readback = arcade_sel ? gder_pkg::VERSION_ARCADE :
                                                gder_pkg::VERSION_STD;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        st.read_data      = readback;
        st.window_enabled = win_on;
        st.offset_x       = ofs_x;
        st.offset_y       = ofs_y;
        expected_status.push_back(st);
    endtask

    task automatic send_command(input gder_pkg::t_opcode op, input logic [23:0] prm);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= prm;
        burst_left--;
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        apply_command(op, prm);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic val);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ARCADE_MODE) begin
            arcade_sel = val;
        end else begin
            rows_512 = val;
        end
    endtask

    task automatic report(input string field, input logic [23:0] want, input logic [23:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(negedge i_clk) begin : check_results
        t_status got;
        t_status want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("gpu_draw_environment_registers regression: fail");
                $finish;
            end else if (o_m_tvalid && i_m_tready) begin
                got.read_data      = o_m_tdata[23:0];
                got.window_enabled = o_m_tdata[24];
                got.offset_x       = o_m_tdata[35:25];
                got.offset_y       = o_m_tdata[46:36];
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.read_data != want.read_data) begin
                        report("read_data", want.read_data, got.read_data);
                    end
                    if (got.window_enabled != want.window_enabled) begin
                        report("window_enabled", 24'(want.window_enabled),
                               24'(got.window_enabled));
                    end
                    if (got.offset_x != want.offset_x) begin
                        report("offset_x", 24'(want.offset_x), 24'(got.offset_x));
                    end
                    if (got.offset_y != want.offset_y) begin
                        report("offset_y", 24'(want.offset_y), 24'(got.offset_y));
                    end
                end
            end
        end
    end

    function automatic logic [23:0] pack_window(input logic [4:0] mw, input logic [4:0] mh,
                                                input logic [4:0] ox, input logic [4:0] oy);
        return {4'd0, oy, ox, mh, mw};
    endfunction

    // zero, a single set bit, or anything
    function automatic logic [4:0] mask_field_pick();
        int r;
        r = $urandom_range(0, 11);
        if (r < 5) begin
            return 5'd1 << r;
        end else if (r == 5) begin
            return 5'd0;
        end
        return 5'($urandom());
    endfunction

    function automatic logic [23:0] random_params(input gder_pkg::t_opcode op);
        logic [23:0]     prm;
        gder_pkg::t_info code;
        prm = 24'($urandom());
        if (op == gder_pkg::OP_TEX_WINDOW && $urandom_range(0, 1) == 0) begin
            prm[9:0] = {mask_field_pick(), mask_field_pick()};
        end else if (op == gder_pkg::OP_INFO && $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
                0: code = gder_pkg::INFO_TEX_WINDOW;
                1: code = gder_pkg::INFO_AREA_START;
                2: code = gder_pkg::INFO_AREA_END;
                3: code = gder_pkg::INFO_DRAW_OFS;
                default: code = gder_pkg::INFO_VERSION;
            endcase
            prm[3:0] = code;
        end
        return prm;
    endfunction

    task automatic test_texture_window();
        send_command(gder_pkg::OP_TEX_WINDOW, 24'h000000);
        send_command(gder_pkg::OP_TEX_WINDOW, pack_window(5'h01, 5'h02, 5'h1F, 5'h1F));
        send_command(gder_pkg::OP_TEX_WINDOW, pack_window(5'h04, 5'h08, 5'h1F, 5'h1F));
        send_command(gder_pkg::OP_INFO, {20'd0, gder_pkg::INFO_TEX_WINDOW});
        send_command(gder_pkg::OP_TEX_WINDOW, pack_window(5'h10, 5'h00, 5'h1F, 5'h1F));
        send_command(gder_pkg::OP_TEX_WINDOW, 24'hFFFFFF);
    endtask

    task automatic test_layouts();
        logic [1:0] sel;
        for (int i = 0; i < 4; i++) begin
            sel = 2'(i);
            write_config(REG_ARCADE_MODE, sel[1]);
            write_config(REG_VRAM_ROWS_512, sel[0]);
            send_command(gder_pkg::OP_AREA_START, 24'hFFFFFF);
            send_command(gder_pkg::OP_DRAW_OFS, sel[0] ? 24'h4003FF : 24'h7FFC00);
            send_command(gder_pkg::OP_INFO, {20'hFFFFF, gder_pkg::INFO_AREA_START});
            send_command(gder_pkg::OP_INFO, {20'd0, gder_pkg::INFO_DRAW_OFS});
        end
    endtask

    task automatic test_info_codes();
        send_command(gder_pkg::OP_AREA_END, 24'h2AAAAA);
        send_command(gder_pkg::OP_INFO, {20'd0, gder_pkg::INFO_AREA_END});
        send_command(gder_pkg::OP_INFO, {20'd0, gder_pkg::INFO_VERSION});
        send_command(gder_pkg::OP_INFO, {20'd0, INFO_RESERVED_LOW});
        send_command(gder_pkg::OP_INFO, {20'hFFFFF, INFO_RESERVED_HIGH});
    endtask

    task automatic test_ignored_opcodes();
        send_command(OP_NOP_5, 24'hFFFFFF);
        send_command(OP_NOP_6, 24'h000000);
        send_command(OP_NOP_7, 24'h5A5A5A);
    endtask

    task automatic test_random_traffic();
        int                useful;
        int                r;
        gder_pkg::t_opcode op;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 4) begin
                write_config(REG_ARCADE_MODE, ph[1]);
                write_config(REG_VRAM_ROWS_512, ph[0]);
            end else begin
                write_config(REG_VRAM_ROWS_512, 1'($urandom()));
                write_config(REG_ARCADE_MODE, 1'($urandom()));
            end
            useful = 0;
            while (useful < RANDOM_ITEMS / RANDOM_PHASES) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    op = gder_pkg::OP_TEX_WINDOW;
                end else if (r < 35) begin
                    op = gder_pkg::OP_AREA_START;
                end else if (r < 50) begin
                    op = gder_pkg::OP_AREA_END;
                end else if (r < 68) begin
                    op = gder_pkg::OP_DRAW_OFS;
                end else if (r < 93) begin
                    op = gder_pkg::OP_INFO;
                end else begin
                    op = gder_pkg::t_opcode'($urandom_range(5, 7));
                end
                send_command(op, random_params(op));
                if (op <= gder_pkg::OP_INFO) begin
                    useful++;
                end
                // in phase 5, after the 60th useful item, hold the sender until the output side is empty
                if (ph == 5 && useful == 60) begin
                    wait_for_results();
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_texture_window();
        test_layouts();
        test_info_codes();
        test_ignored_opcodes();
        test_random_traffic();
        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("gpu_draw_environment_registers regression: pass");
        end else begin
            $display("gpu_draw_environment_registers regression: fail");
        end
        $finish;
    end

endmodule
